// ----- hdl/keyframe_track_interpolator_macros.svh -----
// Assertion macros shared by the keyframe track interpolator.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define KTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define KTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/kti_pkg.sv -----
// Shared types and constants of the keyframe track interpolator.
package kti_pkg;

  localparam int NCOMP     = 9;
  localparam int COMP_W    = 4;
  localparam int VAL_W     = 32;
  localparam int TIME_W    = 26;
  localparam int FC_W      = 11;
  localparam int IDX_W     = 10;
  localparam int CMD_W     = 2;
  localparam int FRAC_W    = 16;

  localparam logic [VAL_W-1:0]  ONE_Q16     = 32'h0001_0000;
  localparam logic [COMP_W-1:0] SCALE_FIRST = 4'd6;
  localparam logic [COMP_W-1:0] LAST_COMP   = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_REWIND = 2'd3
  } cmd_t;

  typedef struct packed {
    logic start;
    logic interp;
  } mac_ctrl_t;

endpackage

// ----- hdl/keyframe_track_interpolator.sv -----
// Top level of the keyframe track interpolator: command sequencer and result register.
//
// Input words arrive on in_valid/in_ready with command, frame_index, component, value,
// frame_time and loop_enable. Write, remove and rewind take effect in the accept cycle
// and produce no output. An update produces nine output words on out_valid/out_ready,
// components 0 to 8 in order, with last set on the ninth.
// An update keeps in_ready low until its ninth word is loaded. The key map is scanned
// for the next key (at most two scans), the time difference of width DW (27 at 1024
// frames) is divided when interpolating, the key map memory is read one slot per read
// and check state pair, the divider resolves one quotient bit per cycle, and a
// shared multiplier makes each interpolation in two partial products.
// The user writes frame_count through cfg_write/cfg_data only while the block is idle; the block does not enforce it.
// After reset the memories are swept over all NCOMP*MAX_FRAMES frame value slots (9216 at 1024
// frames); in_ready stays low during the sweep.
// The output word sits in a register: while out_ready is low the sequencer holds the
// next result, and after the ninth word is loaded a new input word is taken even if
// that word has not yet been consumed.
`include "keyframe_track_interpolator_macros.svh"
module keyframe_track_interpolator import kti_pkg::*; #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [FC_W-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic [IDX_W-1:0]         frame_index,
  input  logic [COMP_W-1:0]        component,
  input  logic signed [VAL_W-1:0]  value,
  input  logic [TIME_W-1:0]        frame_time,
  input  logic                     loop_enable,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COMP_W-1:0]        out_component,
  output logic signed [VAL_W-1:0]  out_value,
  output logic                     last
);

  localparam int SW  = $clog2(MAX_FRAMES);
  localparam int FW  = SW + 1;
  localparam int AW  = $clog2(NCOMP * MAX_FRAMES);
  localparam int DW  = ((SW + FRAC_W > TIME_W) ? SW + FRAC_W : TIME_W) + 1;
  localparam int UW  = DW - 1;
  localparam int VW  = SW + 2;
  localparam int IW  = (IDX_W > FW) ? IDX_W : FW;
  localparam int CW  = (FC_W > FW) ? FC_W : FW;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_RD, S_CHK, S_SCAN_RD, S_SCAN_CHK, S_ADV, S_CALC,
    S_DIV, S_RD_A, S_RD_B, S_MAC_GO, S_MAC_WAIT, S_EMIT
  } state_t;

  state_t                  state;
  logic [FC_W-1:0]         frame_count;
  logic [SW-1:0]           current_key;
  logic [SW-1:0]           cur;
  logic [SW-1:0]           nxt;
  logic [FW-1:0]           scan_s;
  logic                    phase;
  logic                    interp;
  logic                    loop_r;
  logic [TIME_W-1:0]       ft_r;
  logic signed [DW-1:0]    t_r;
  logic signed [VAL_W-1:0] a_r;
  logic signed [VAL_W-1:0] res_r;
  logic [COMP_W-1:0]       comp_j;

  logic [CW-1:0]           fc_wide;
  logic [FW-1:0]           fc_eff;
  logic [IW-1:0]           idx_ext;
  logic                    idx_ok;
  logic                    accept;
  logic                    load;
  logic [UW-1:0]           ft_u;
  logic [UW-1:0]           cur_q;
  logic [UW-1:0]           nxt_q;
  logic signed [DW-1:0]    diff;
  logic [VW-1:0]           span;

  logic                    clearing;
  logic                    key_we;
  logic                    key_wdata;
  logic [SW-1:0]           key_raddr;
  logic                    key_rdata;
  logic                    frame_we;
  logic [AW-1:0]           frame_waddr;
  logic [AW-1:0]           frame_raddr;
  logic [VAL_W-1:0]        frame_rdata;

  logic                    div_start;
  logic                    div_done;
  logic signed [DW-1:0]    div_q;
  mac_ctrl_t               mac_ctrl;
  logic                    mac_done;
  logic signed [VAL_W-1:0] mac_result;

  function automatic logic [AW-1:0] slot_addr(logic [SW-1:0] s, logic [COMP_W-1:0] c);
    return AW'({s, 3'b000}) + AW'(s) + AW'(c);
  endfunction

  always_comb begin
    fc_wide = CW'(frame_count);
    if (fc_wide == '0) begin
      fc_eff = FW'(1);
    end else if (fc_wide > CW'(MAX_FRAMES)) begin
      fc_eff = FW'(MAX_FRAMES);
    end else begin
      fc_eff = FW'(fc_wide);
    end
    idx_ext = IW'(frame_index);
    idx_ok  = idx_ext < IW'(fc_eff);
    accept  = in_valid && in_ready;
    load    = (state == S_EMIT) && (!out_valid || out_ready);
    ft_u    = UW'(ft_r);
    cur_q   = UW'({cur, {FRAC_W{1'b0}}});
    nxt_q   = UW'({nxt, {FRAC_W{1'b0}}});
    diff    = $signed({1'b0, ft_u}) - $signed({1'b0, cur_q});
    if (nxt > cur) begin
      span = VW'(nxt) - VW'(cur);
    end else begin
      span = VW'(nxt) + VW'(fc_eff) - VW'(cur);
    end
  end

  assign in_ready = (state == S_IDLE) && !clearing;

  always_comb begin
    key_we      = 1'b0;
    key_wdata   = 1'b0;
    frame_we    = 1'b0;
    frame_waddr = slot_addr(idx_ext[SW-1:0], component);
    if (accept && (command == CMD_WRITE) && idx_ok && (component <= LAST_COMP)) begin
      key_we    = 1'b1;
      key_wdata = 1'b1;
      frame_we  = 1'b1;
    end
    if (accept && (command == CMD_REMOVE) && idx_ok && (idx_ext != '0)) begin
      key_we = 1'b1;
    end
    case (state)
      S_CHK_RD: key_raddr = current_key;
      default:  key_raddr = scan_s[SW-1:0];
    endcase
    case (state)
      S_RD_B:  frame_raddr = slot_addr(nxt, comp_j);
      default: frame_raddr = slot_addr(cur, comp_j);
    endcase
    div_start       = (state == S_CALC) && ((nxt > cur) || loop_r);
    mac_ctrl.start  = (state == S_MAC_GO);
    mac_ctrl.interp = interp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_count <= FC_W'(1);
      current_key <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        frame_count <= cfg_data;
      end
      if (load) begin
        out_valid     <= 1'b1;
        out_component <= comp_j;
        out_value     <= res_r;
        last          <= (comp_j == LAST_COMP);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ft_r   <= frame_time;
            loop_r <= loop_enable;
            if (command == CMD_REWIND) begin
              current_key <= '0;
            end
            if (command == CMD_UPDATE) begin
              state <= S_CHK_RD;
            end
          end
        end
        S_CHK_RD: begin
          phase <= 1'b0;
          if (FW'(current_key) >= fc_eff) begin
            cur    <= '0;
            scan_s <= FW'(1);
            state  <= S_SCAN_RD;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          cur    <= key_rdata ? current_key : '0;
          scan_s <= (key_rdata ? FW'(current_key) : '0) + FW'(1);
          state  <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (scan_s >= fc_eff) begin
            nxt   <= '0;
            state <= S_ADV;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (key_rdata) begin
            nxt   <= scan_s[SW-1:0];
            state <= S_ADV;
          end else begin
            scan_s <= scan_s + FW'(1);
            state  <= S_SCAN_RD;
          end
        end
        S_ADV: begin
          state <= S_CALC;
          if (!phase && (ft_u > nxt_q)) begin
            if ((nxt < cur) && (ft_u < cur_q)) begin
              cur    <= '0;
              scan_s <= FW'(1);
              phase  <= 1'b1;
              state  <= S_SCAN_RD;
            end else if (nxt > cur) begin
              cur    <= nxt;
              scan_s <= FW'(nxt) + FW'(1);
              phase  <= 1'b1;
              state  <= S_SCAN_RD;
            end
          end
        end
        S_CALC: begin
          current_key <= cur;
          comp_j      <= '0;
          if ((nxt > cur) || loop_r) begin
            interp <= 1'b1;
            state  <= S_DIV;
          end else begin
            interp <= 1'b0;
            state  <= S_RD_A;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_r   <= div_q;
            state <= S_RD_A;
          end
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          a_r   <= $signed(frame_rdata);
          state <= S_MAC_GO;
        end
        S_MAC_GO: begin
          state <= S_MAC_WAIT;
        end
        S_MAC_WAIT: begin
          if (mac_done) begin
            res_r <= mac_result;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            if (comp_j == LAST_COMP) begin
              state <= S_IDLE;
            end else begin
              comp_j <= comp_j + 1'b1;
              state  <= S_RD_A;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  kti_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .SW         (SW),
    .AW         (AW)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .key_we      (key_we),
    .key_waddr   (idx_ext[SW-1:0]),
    .key_wdata   (key_wdata),
    .key_raddr   (key_raddr),
    .key_rdata   (key_rdata),
    .frame_we    (frame_we),
    .frame_waddr (frame_waddr),
    .frame_wdata (value),
    .frame_raddr (frame_raddr),
    .frame_rdata (frame_rdata)
  );

  kti_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  kti_mac #(
    .DW (DW)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a      (a_r),
    .b      ($signed(frame_rdata)),
    .t      (t_r),
    .done   (mac_done),
    .result (mac_result)
  );

  `KTI_ASSERT_NOW(a_last_is_final, out_valid && last, out_component == LAST_COMP, "last on wrong component")
  `KTI_ASSERT_NEXT(a_final_to_idle, load && (comp_j == LAST_COMP), state == S_IDLE, "sequencer did not finish")
  `KTI_ASSERT_NEXT(a_key_in_range, state == S_CALC, FW'(current_key) < fc_eff, "current key beyond frame count")
  `KTI_ASSERT_NOW(a_no_work_clearing, clearing, state == S_IDLE, "update running during sweep")

endmodule

// ----- hdl/kti_store.sv -----
// Key map and frame value memories with the clearing sweep after reset.
module kti_store import kti_pkg::*; #(
  parameter int MAX_FRAMES = 1024,
  parameter int SW = 10,
  parameter int AW = 14
) (
  input  logic             clk,
  input  logic             rst,
  output logic             clearing,
  input  logic             key_we,
  input  logic [SW-1:0]    key_waddr,
  input  logic             key_wdata,
  input  logic [SW-1:0]    key_raddr,
  output logic             key_rdata,
  input  logic             frame_we,
  input  logic [AW-1:0]    frame_waddr,
  input  logic [VAL_W-1:0] frame_wdata,
  input  logic [AW-1:0]    frame_raddr,
  output logic [VAL_W-1:0] frame_rdata
);

  localparam int DEPTH = NCOMP * MAX_FRAMES;

  logic             key_map [MAX_FRAMES];
  logic [VAL_W-1:0] frame_store [DEPTH];
  logic [AW-1:0]    clr_cnt;
  logic [VAL_W-1:0] clr_val;

  always_comb begin
    if ((clr_cnt >= AW'(SCALE_FIRST)) && (clr_cnt < AW'(NCOMP))) begin
      clr_val = ONE_Q16;
    end else begin
      clr_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      frame_store[clr_cnt] <= clr_val;
      if (clr_cnt < AW'(MAX_FRAMES)) begin
        key_map[clr_cnt[SW-1:0]] <= (clr_cnt == '0);
      end
    end else begin
      if (frame_we) begin
        frame_store[frame_waddr] <= frame_wdata;
      end
      if (key_we) begin
        key_map[key_waddr] <= key_wdata;
      end
    end
    key_rdata   <= key_map[key_raddr];
    frame_rdata <= frame_store[frame_raddr];
  end

endmodule

// ----- hdl/kti_div.sv -----
// Bit-serial signed divider that truncates toward zero.
module kti_div #(
  parameter int DW = 27,
  parameter int VW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic        [VW-1:0] divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int CNW = $clog2(DW + 1);

  logic          busy;
  logic [CNW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] mag;
  logic [VW:0]   rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem_sh;
  logic          fits;
  logic [DW-1:0] mag_next;

  always_comb begin
    rem_sh   = {rem[VW-1:0], mag[DW-1]};
    fits     = rem_sh >= {1'b0, dvs};
    mag_next = {mag[DW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[DW-1];
        mag  <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        mag <= mag_next;
        rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(DW - 1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? -$signed(mag_next) : $signed(mag_next);
        end
      end
    end
  end

endmodule

// ----- hdl/kti_mac.sv -----
// Shared multiplier that forms one rounded, saturated linear interpolation, or passes a through when interp is off.
module kti_mac import kti_pkg::*; #(
  parameter int DW = 27
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctrl_t               ctrl,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  logic signed [DW-1:0]    t,
  output logic                    done,
  output logic signed [VAL_W-1:0] result
);

  localparam int MW  = FRAC_W + 1;
  localparam int DLW = VAL_W + 1;
  localparam int PW  = DLW + MW;
  localparam int ACW = DLW + DW;
  localparam int RW  = ACW - FRAC_W;
  localparam int SMW = RW + 1;

  logic [2:0]              step;
  logic                    interp;
  logic signed [VAL_W-1:0] a_r;
  logic signed [DLW-1:0]   delta;
  logic signed [MW-1:0]    mop;
  logic signed [PW-1:0]    prod;
  logic signed [ACW-1:0]   acc;
  logic signed [RW-1:0]    rnd;
  logic signed [SMW-1:0]   sum;
  logic [VAL_W-1:0]        sat;

  always_comb begin
    if (step == 3'd1) begin
      mop = $signed({1'b0, t[FRAC_W-1:0]});
    end else begin
      mop = MW'($signed(t[DW-1:FRAC_W]));
    end
    rnd = RW'((acc + ACW'(32768)) >>> FRAC_W);
    sum = SMW'(a_r) + SMW'(rnd);
    if (sum[SMW-1:VAL_W-1] != {(SMW - VAL_W + 1){sum[VAL_W-1]}}) begin
      sat = sum[SMW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (step)
        3'd0: begin
          if (ctrl.start) begin
            a_r    <= a;
            interp <= ctrl.interp;
            delta  <= DLW'(b) - DLW'(a);
            step   <= 3'd1;
          end
        end
        3'd1: begin
          prod <= delta * mop;
          step <= 3'd2;
        end
        3'd2: begin
          acc  <= ACW'(prod);
          prod <= delta * mop;
          step <= 3'd3;
        end
        3'd3: begin
          acc  <= acc + (ACW'(prod) <<< FRAC_W);
          step <= 3'd4;
        end
        3'd4: begin
          result <= interp ? $signed(sat) : a_r;
          done   <= 1'b1;
          step   <= 3'd0;
        end
        default: begin
          step <= 3'd0;
        end
      endcase
    end
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the keyframe track interpolator.
`timescale 1ns / 100ps

module tb import kti_pkg::*; ();

  typedef struct {
    logic [COMP_W-1:0] comp;
    logic [VAL_W-1:0]  val;
    logic              last;
  } track_result_t;

  class track_scoreboard;
    bit              key_map[1024];
    int              frame_store[1024][NCOMP];
    int unsigned     cur_key;
    int unsigned     frame_cnt;
    track_result_t   pending_results[$];
    int              errors;

    function new();
      for (int s = 0; s < 1024; s++) begin
        key_map[s] = 0;
        for (int c = 0; c < NCOMP; c++) frame_store[s][c] = 0;
      end
      key_map[0] = 1;
      for (int c = 6; c < NCOMP; c++) frame_store[0][c] = 32'h0001_0000;
      cur_key = 0;
      frame_cnt = 1;
      errors = 0;
    endfunction

    function int unsigned slots_in_use();
      if (frame_cnt == 0) return 1;
      if (frame_cnt > 1024) return 1024;
      return frame_cnt;
    endfunction

    function int unsigned following_key(int unsigned from, int unsigned fc);
      for (int unsigned s = from + 1; s < fc; s++)
        if (key_map[s]) return s;
      return 0;
    endfunction

    function longint blend(longint a, longint b, longint t);
      longint p, q, r;
      p = (b - a) * t;
      q = p + 32768;
      if (q >= 0) r = q / 65536;
      else r = -((-q + 65535) / 65536);
      r = a + r;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function void note_word(cmd_t cmd, int unsigned idx, int unsigned comp, int val,
                            longint ft, bit loop_on);
      int unsigned fc, cur, nxt;
      longint diff, t;
      bit interp;
      track_result_t res;
      fc = slots_in_use();
      t = 0;
      interp = 1;
      case (cmd)
        CMD_WRITE: begin
          if (idx < fc && comp < NCOMP) begin
            key_map[idx] = 1;
            frame_store[idx][comp] = val;
          end
        end
        CMD_REMOVE: begin
          if (idx != 0 && idx < fc) key_map[idx] = 0;
        end
        CMD_REWIND: begin
          cur_key = 0;
        end
        default: begin
          cur = cur_key;
          if (cur >= fc || !key_map[cur]) cur = 0;
          nxt = following_key(cur, fc);
          if (ft > (longint'(nxt) << 16)) begin
            if (nxt < cur && ft < (longint'(cur) << 16)) begin
              cur = 0;
              nxt = following_key(0, fc);
            end else if (nxt > cur) begin
              cur = nxt;
              nxt = following_key(cur, fc);
            end
          end
          cur_key = cur;
          diff = ft - (longint'(cur) << 16);
          if (nxt > cur) t = diff / longint'(nxt - cur);
          else if (loop_on) t = diff / longint'(nxt + fc - cur);
          else interp = 0;
          for (int j = 0; j < NCOMP; j++) begin
            res.comp = COMP_W'(j);
            res.val = VAL_W'(interp ? blend(frame_store[cur][j], frame_store[nxt][j], t)
                                    : longint'(frame_store[cur][j]));
            res.last = (j == NCOMP - 1);
            pending_results.insert(pending_results.size(), res);
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [COMP_W-1:0] comp, logic [VAL_W-1:0] val, logic lst);
      track_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word component %0d value %h", comp, val));
      end else begin
        want = pending_results.pop_front();
        if (comp !== want.comp)
          report($sformatf("component %0d, expected %0d", comp, want.comp));
        if (val !== want.val)
          report($sformatf("component %0d value %h, expected %h", want.comp, val, want.val));
        if (lst !== want.last)
          report($sformatf("component %0d last %b, expected %b", want.comp, lst, want.last));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [FC_W-1:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [CMD_W-1:0] command = CMD_UPDATE;
  logic [IDX_W-1:0] frame_index = 0;
  logic [COMP_W-1:0] component = 0;
  logic signed [VAL_W-1:0] value = 0;
  logic [TIME_W-1:0] frame_time = 0;
  logic loop_enable = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [COMP_W-1:0] out_component;
  logic signed [VAL_W-1:0] out_value;
  logic last;

  track_scoreboard sb = new();
  int idle_pct = 13;
  int hold_off_cycles = 0;
  longint anim_time = 0;

  keyframe_track_interpolator uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .frame_index(frame_index), .component(component), .value(value),
    .frame_time(frame_time), .loop_enable(loop_enable),
    .out_valid(out_valid), .out_ready(out_ready), .out_component(out_component),
    .out_value(out_value), .last(last)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_component, out_value, last);
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready = 0;
      end else begin
        out_ready = ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic send_word(cmd_t cmd, int unsigned idx, int unsigned comp, int val,
                           int unsigned ft, bit loop_on);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    command = cmd;
    frame_index = IDX_W'(idx);
    component = COMP_W'(comp);
    value = val;
    frame_time = TIME_W'(ft);
    loop_enable = loop_on;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(cmd, idx, comp, val, longint'(ft), loop_on);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_frame_count(int unsigned fc);
    cfg_write = 1;
    cfg_data = FC_W'(fc);
    @(negedge clk);
    cfg_write = 0;
    sb.frame_cnt = fc;
  endtask

  task automatic random_word();
    int unsigned fc, pick, idx, comp, ft;
    int val;
    bit lp;
    fc = sb.slots_in_use();
    pick = $urandom_range(99);
    idx = ($urandom_range(99) < 85) ? $urandom_range(fc - 1) : $urandom_range(1023);
    comp = ($urandom_range(99) < 90) ? $urandom_range(8) : $urandom_range(15);
    lp = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: val = $urandom;
      1: val = ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
      default: val = ($urandom_range(16) - 8) * 65536 + $urandom_range(65535);
    endcase
    anim_time += longint'($urandom_range(98304));
    if (anim_time >= longint'(fc) * 65536) anim_time = longint'($urandom_range(65535));
    ft = ($urandom_range(9) == 0) ? $urandom_range(26'h3ff_ffff) : 32'(anim_time);
    if (pick < 35) send_word(CMD_UPDATE, idx, comp, val, ft, lp);
    else if (pick < 80) send_word(CMD_WRITE, idx, comp, val, ft, lp);
    else if (pick < 90) send_word(CMD_REMOVE, idx, comp, val, ft, lp);
    else send_word(CMD_REWIND, idx, comp, val, ft, lp);
  endtask

  initial begin
    int unsigned phase_fc[8];
    phase_fc = '{4, 16, 0, 64, 1024, 2047, 3, 2};
    repeat (4) @(negedge clk);
    rst = 0;

    send_word(CMD_UPDATE, 0, 0, 0, 0, 0);
    send_word(CMD_UPDATE, 0, 0, 0, 26'h3ff_ffff, 1);
    drain();
    set_frame_count(16);
    for (int c = 0; c < NCOMP; c++) send_word(CMD_WRITE, 4, c, (c + 1) * 65536, 0, 0);
    send_word(CMD_WRITE, 8, 2, 32'h7fff_ffff, 0, 0);
    send_word(CMD_WRITE, 8, 12, 32'h1234_5678, 0, 0);
    send_word(CMD_WRITE, 20, 1, -65536, 0, 0);
    send_word(CMD_REMOVE, 0, 0, 0, 0, 0);
    send_word(CMD_UPDATE, 0, 0, 0, 2 * 65536 + 32768, 0);
    send_word(CMD_UPDATE, 0, 0, 0, 5 * 65536, 0);
    send_word(CMD_UPDATE, 0, 0, 0, 12 * 65536, 1);
    send_word(CMD_UPDATE, 0, 0, 0, 12 * 65536, 0);
    send_word(CMD_REMOVE, 8, 0, 0, 0, 0);
    send_word(CMD_UPDATE, 0, 0, 0, 6 * 65536, 1);
    send_word(CMD_REWIND, 0, 0, 0, 0, 0);
    send_word(CMD_UPDATE, 0, 0, 0, 1 * 65536, 1);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_frame_count(phase_fc[p]);
      anim_time = 0;
      idle_pct = (p == 3) ? 0 : 13;
      if (p == 1) hold_off_cycles = 400;
      for (int n = 0; n < 36; n++) random_word();
      drain();
    end

    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
